### rtl/samoc_pkg.sv
// ----------------------------------------------------------------------------
// samoc_pkg
// Shared types, constants and the control store for the shift-and-add
// multiplier with overflow check.
// ----------------------------------------------------------------------------
package samoc_pkg;

  localparam int unsigned OperandWidthDef = 32;
  localparam int unsigned FieldWidth      = 32;

  typedef struct packed {
    logic [FieldWidth-1:0] multiplicand;
    logic [FieldWidth-1:0] multiplier;
  } in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] product;
    logic                  overflow;
  } out_t;

  // Conditions that a control word may test before jumping.
  typedef enum logic [1:0] {
    CondAccept   = 2'd0,
    CondScanDone = 2'd1,
    CondOutFree  = 2'd2,
    CondAlways   = 2'd3
  } cond_e;

  localparam int unsigned NumSteps = 3;
  localparam int unsigned PcWidth  = 2;

  localparam logic [PcWidth-1:0] StepIdle   = 2'd0;
  localparam logic [PcWidth-1:0] StepLoop   = 2'd1;
  localparam logic [PcWidth-1:0] StepCommit = 2'd2;

  // One control word per step. When the condition holds the program counter
  // moves to the target, otherwise it stays on the same step.
  typedef struct packed {
    logic               in_ready;
    logic               iterate;
    logic               commit;
    cond_e              cond;
    logic [PcWidth-1:0] target;
  } uword_t;

  localparam uword_t Ucode [NumSteps] = '{
    '{in_ready: 1'b1, iterate: 1'b0, commit: 1'b0, cond: CondAccept,   target: StepLoop},
    '{in_ready: 1'b0, iterate: 1'b1, commit: 1'b0, cond: CondScanDone, target: StepCommit},
    '{in_ready: 1'b0, iterate: 1'b0, commit: 1'b1, cond: CondOutFree,  target: StepIdle}
  };

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic iterate;
    logic commit;
  } dp_ctrl_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

### rtl/shift_add_multiplier_overflow_check_top.sv
// ----------------------------------------------------------------------------
// shift_add_multiplier_overflow_check_top
// Unsigned shift-and-add multiplier with a conservative overflow flag.
// ----------------------------------------------------------------------------
// Takes one request of two unsigned operands and returns their product, or
// the overflow flag with a zero product when the operands' bit lengths add up
// to the operand width or more. A three-step control store sequences one
// shared adder: a step to take the request, a loop step that runs until
// both operands have shifted out, and a step to write the result register.
// The accumulate loop handles one bit per cycle. The result register lets
// the next request be taken while a result still waits.
module shift_add_multiplier_overflow_check_top import samoc_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [PcWidth-1:0] pc_q, pc_d;
  logic               out_valid_q, out_valid_d;
  uword_t             word;
  dp_ctrl_t           dp_ctrl;
  dp_stat_t           dp_stat;
  logic               accept;
  logic               out_free;
  logic               cond_true;

  assign word     = Ucode[pc_q];
  assign accept   = word.in_ready && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (word.cond)
      CondAccept:   cond_true = in_valid_i;
      CondScanDone: cond_true = dp_stat.scan_done;
      CondOutFree:  cond_true = out_free;
      CondAlways:   cond_true = 1'b1;
      default:      cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (cond_true) begin
      pc_d = word.target;
    end
  end

  assign dp_ctrl.load    = accept;
  assign dp_ctrl.iterate = word.iterate;
  assign dp_ctrl.commit  = word.commit && cond_true;

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  samoc_datapath #(
    .OperandWidth(OperandWidth)
  ) u_datapath (
    .clk_i     (clk_i),
    .in_data_i (in_data_i),
    .ctrl_i    (dp_ctrl),
    .stat_o    (dp_stat),
    .out_data_o(out_data_o)
  );

  assign in_ready_o  = word.in_ready;
  assign out_valid_o = out_valid_q;

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result register written while a result was pending");

  // Only one request is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while another was in work");

  // An overflowed result carries a zero product.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.product == '0)
    else $error("overflow flagged with a non-zero product");

endmodule

### rtl/samoc_datapath.sv
// ----------------------------------------------------------------------------
// samoc_datapath
// Operand registers, shift-and-add accumulator, bit-length counters and the
// result register.
// ----------------------------------------------------------------------------
module samoc_datapath import samoc_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef
) (
  input  logic     clk_i,
  input  in_t      in_data_i,
  input  dp_ctrl_t ctrl_i,
  output dp_stat_t stat_o,
  output out_t     out_data_o
);

  localparam int unsigned CntWidth = $clog2(OperandWidth + 1);
  localparam int unsigned SumWidth = CntWidth + 1;

  logic [OperandWidth-1:0] mcand_q, mcand_d;
  logic [OperandWidth-1:0] mplier_q, mplier_d;
  logic [OperandWidth-1:0] scan_b_q, scan_b_d;
  logic [OperandWidth-1:0] acc_q, acc_d;
  logic [CntWidth-1:0]     len_a_q, len_a_d;
  logic [CntWidth-1:0]     len_b_q, len_b_d;
  out_t                    out_q, out_d;
  logic [SumWidth-1:0]     len_sum;
  logic                    ovf;

  // The multiplicand is consumed from the bottom while the multiplier moves
  // up; a right-shifting copy of the multiplier gives its bit length.
  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    scan_b_d = scan_b_q;
    acc_d    = acc_q;
    len_a_d  = len_a_q;
    len_b_d  = len_b_q;
    if (ctrl_i.load) begin
      mcand_d  = OperandWidth'(in_data_i.multiplicand);
      mplier_d = OperandWidth'(in_data_i.multiplier);
      scan_b_d = OperandWidth'(in_data_i.multiplier);
      acc_d    = '0;
      len_a_d  = '0;
      len_b_d  = '0;
    end else if (ctrl_i.iterate) begin
      if (mcand_q[0]) begin
        acc_d = acc_q + mplier_q;
      end
      mplier_d = mplier_q << 1;
      mcand_d  = mcand_q >> 1;
      scan_b_d = scan_b_q >> 1;
      len_a_d  = len_a_q + CntWidth'(|mcand_q);
      len_b_d  = len_b_q + CntWidth'(|scan_b_q);
    end
  end

  assign len_sum = SumWidth'(len_a_q) + SumWidth'(len_b_q);
  assign ovf     = (len_sum >= SumWidth'(OperandWidth));

  always_comb begin
    out_d = out_q;
    if (ctrl_i.commit) begin
      out_d.overflow = ovf;
      out_d.product  = ovf ? '0 : FieldWidth'(acc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    scan_b_q <= scan_b_d;
    acc_q    <= acc_d;
    len_a_q  <= len_a_d;
    len_b_q  <= len_b_d;
    out_q    <= out_d;
  end

  assign stat_o.scan_done = (mcand_q == '0) && (scan_b_q == '0);
  assign out_data_o       = out_q;

endmodule

### dv/tb_shift_add_multiplier_overflow_check_top.sv
// ----------------------------------------------------------------------------
// tb_shift_add_multiplier_overflow_check_top
// Self-checking testbench for the shift-and-add multiplier with overflow flag.
// ----------------------------------------------------------------------------
// Drives operand requests through the valid/ready input, predicts each product
// and overflow flag from the operands' bit lengths, and compares every result
// taken from the output in order. Both sides idle in random bursts, except in
// the closing stretch of the run.
// ----------------------------------------------------------------------------
module tb_shift_add_multiplier_overflow_check_top import samoc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom   = 600;
  localparam int unsigned QuietTail   = 100;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumDirected = 20;

  // Operand pairs, multiplicand in the upper half.
  localparam logic [63:0] DirectedPairs [NumDirected] = '{
    64'h0000_0000_0000_0000,
    64'h0000_0000_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0001_0000_0001,
    64'h0000_0001_7FFF_FFFF,
    64'h0000_0001_3FFF_FFFF,
    64'h0000_FFFF_0000_FFFF,
    64'h0000_FFFF_0000_7FFF,
    64'h0000_8000_0000_7FFF,
    64'h8000_0000_0000_0000,
    64'h4000_0000_0000_0001,
    64'h4000_0000_0000_0000,
    64'h2000_0000_0000_0001,
    64'h0000_0000_0000_0001,
    64'hAAAA_AAAA_5555_5555,
    64'h0000_5555_0000_AAAA,
    64'h0001_0000_0000_7FFF,
    64'h0000_8000_0000_FFFF,
    64'h0000_0000_7FFF_FFFF
  };

  class product_board;
    out_t        pending_products [$];
    int unsigned errors = 0;

    static function int unsigned bit_length(logic [FieldWidth-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < FieldWidth; i++) begin
        if (v[i]) n = i + 1;
      end
      return n;
    endfunction

    // Once the bit lengths sum below the width the product always fits, so
    // the stripped shift-and-add loop reduces to a plain multiplication.
    static function out_t compute_product(in_t req);
      out_t        res;
      logic [63:0] full;
      int unsigned len_a;
      int unsigned len_b;
      len_a = bit_length(req.multiplicand);
      len_b = bit_length(req.multiplier);
      res.overflow = (len_a + len_b >= OperandWidthDef);
      full = {32'b0, req.multiplicand} * {32'b0, req.multiplier};
      res.product = res.overflow ? '0 : full[FieldWidth-1:0];
      return res;
    endfunction

    function void note_request(in_t req);
      pending_products.push_back(compute_product(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result, expected none, got product %h overflow %b",
                 $time, got.product, got.overflow);
        errors++;
        return;
      end
      want = pending_products.pop_front();
      if (got.product !== want.product) begin
        $display("%0t: product expected %h got %h", $time, want.product, got.product);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b got %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_products.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  bit           quiet = 1'b0;
  product_board board = new();

  shift_add_multiplier_overflow_check_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Handshakes are sampled at the edge, before any registered update lands.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_request(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  function automatic logic [FieldWidth-1:0] operand_of_length(int len);
    logic [FieldWidth-1:0] v;
    v = $urandom;
    if (len == 0) return '0;
    if (len < FieldWidth) v &= (32'h1 << len) - 1;
    v[len-1] = 1'b1;
    return v;
  endfunction

  // At least half of the requests sit on the overflow boundary, where the flag flips.
  function automatic in_t random_request();
    in_t req;
    int  len_a;
    int  len_b;
    int  tz;
    if ($urandom_range(0, 3) == 0) begin
      req.multiplicand = $urandom;
      req.multiplier   = $urandom;
      return req;
    end
    len_a = $urandom_range(0, 32);
    case ($urandom_range(0, 2))
      0: len_b = 31 - len_a;
      1: len_b = 32 - len_a;
      default: len_b = $urandom_range(0, 32 - len_a);
    endcase
    if (len_b < 0) len_b = 0;
    req.multiplicand = operand_of_length(len_a);
    req.multiplier   = operand_of_length(len_b);
    if (len_a > 1 && $urandom_range(0, 1) == 1) begin
      tz = $urandom_range(1, len_a - 1);
      req.multiplicand &= ~((32'h1 << tz) - 1);
    end
    return req;
  endfunction

  task automatic send_request(in_t req, bit allow_gap);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Holds off the next request until every outstanding result has returned.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_request(in_t'(DirectedPairs[i]), 1'b1);
    end
    wait_for_drain();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) wait_for_drain();
      quiet = (i >= NumRandom - QuietTail);
      send_request(random_request(), !quiet);
    end
    in_valid_i <= 1'b0;

    // The last request is noted at the edge just passed, so count from the next.
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### shift_add_multiplier_overflow_check_top.f
rtl/samoc_pkg.sv
rtl/samoc_datapath.sv
rtl/shift_add_multiplier_overflow_check_top.sv
dv/tb_shift_add_multiplier_overflow_check_top.sv
